### hw/rtl/sdpd_pkg.sv
`timescale 1ns / 1ps

package sdpd_pkg;

   // Angles are unsigned hundredths of a degree
   localparam int ANGLE_W = 16;
   localparam int ERR_W   = 15;
   localparam int LOAD_W  = 11;
   localparam int COUNT_W = 8;
   localparam int SERVOS  = 4;
   localparam int IDX_W   = 2;

   localparam logic [ANGLE_W-1:0] FULL_CIRCLE = 16'd36000;
   localparam logic [ANGLE_W-1:0] HALF_CIRCLE = 16'd18000;

   // x / 10 == (x * 52429) >> 19, exact for x up to well past 18000
   localparam logic [31:0] DIV10_MUL   = 32'd52429;
   localparam int          DIV10_SHIFT = 19;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_ERROR_THRESHOLD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLES_NEEDED     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_FRONT_RIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_FRONT_LEFT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_BACK_RIGHT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_BACK_LEFT   = 3'd5;

   localparam logic [ERR_W-1:0]   RST_ERROR_THRESHOLD = 15'd20;
   localparam logic [COUNT_W-1:0] RST_SAMPLES_NEEDED  = 8'd1;
   localparam logic [ANGLE_W-1:0] RST_TARGET_FRONT    = 16'd9000;
   localparam logic [ANGLE_W-1:0] RST_TARGET_BACK     = 16'd27000;

   // Result fields produced by the tracker for one sample
   typedef struct packed {
      logic [IDX_W-1:0]  servo_out;
      logic              read_failed;
      logic [ERR_W-1:0]  angle_err;
      logic [LOAD_W-1:0] load_tenths;
      logic              pressure;
      logic              changed;
      logic              front_any;
      logic              back_any;
      logic              left_any;
      logic              right_any;
   } rsp_type;

endpackage

### hw/rtl/sdpd_err.sv
`timescale 1ns / 1ps

// Circular distance between a (possibly mirrored) servo angle and its target
module sdpd_err import sdpd_pkg::*; (
   input  logic [IDX_W-1:0]   servo_index,
   input  logic [ANGLE_W-1:0] servo_angle,
   input  logic [ANGLE_W-1:0] target,
   output logic [ERR_W-1:0]   angle_err
);

   logic [ANGLE_W-1:0] phys;
   logic [ANGLE_W-1:0] mirrored;
   logic [ANGLE_W-1:0] tgt;
   logic [ANGLE_W-1:0] diff;
   logic [ANGLE_W-1:0] folded;

   always_comb begin
      // A 16-bit value is below twice a full circle: one subtract wraps it
      phys = (servo_angle >= FULL_CIRCLE) ? servo_angle - FULL_CIRCLE : servo_angle;
      tgt  = (target >= FULL_CIRCLE) ? target - FULL_CIRCLE : target;

      // Right-side servos (even index) are mounted mirrored
      if (servo_index[0] == 1'b0) begin
         mirrored = (phys == '0) ? '0 : FULL_CIRCLE - phys;
      end else begin
         mirrored = phys;
      end

      diff   = (mirrored >= tgt) ? mirrored - tgt : tgt - mirrored;
      folded = (diff > HALF_CIRCLE) ? FULL_CIRCLE - diff : diff;
      angle_err = folded[ERR_W-1:0];
   end

endmodule

### hw/rtl/sdpd_track.sv
`timescale 1ns / 1ps

// Per-servo over-threshold counters and pressure flags, updated once per sample
module sdpd_track import sdpd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic [IDX_W-1:0]   servo_index,
   input  logic               read_ok,
   input  logic [ERR_W-1:0]   angle_err,
   input  logic [ERR_W-1:0]   error_threshold,
   input  logic [COUNT_W-1:0] samples_needed,
   output rsp_type            rsp
);

   logic [COUNT_W-1:0] count_ff [SERVOS];
   logic [COUNT_W-1:0] count_in [SERVOS];
   logic [SERVOS-1:0]  flag_ff;
   logic [SERVOS-1:0]  flag_in;

   logic               over;
   logic [COUNT_W-1:0] cur_count;
   logic [COUNT_W-1:0] new_count;
   logic               new_flag;
   logic [ERR_W-1:0]   err_used;
   logic [31:0]        prod;

   // Next count and flag of the addressed servo
   always_comb begin
      cur_count = count_ff[servo_index];
      over      = angle_err > error_threshold;
      if (over) begin
         new_count = (cur_count == '1) ? cur_count : cur_count + COUNT_W'(1);
         new_flag  = flag_ff[servo_index] | (new_count >= samples_needed);
      end else begin
         new_count = '0;
         new_flag  = 1'b0;
      end

      for (int i = 0; i < SERVOS; i++) begin
         count_in[i] = count_ff[i];
      end
      flag_in = flag_ff;
      if (read_ok) begin
         count_in[servo_index] = new_count;
         flag_in[servo_index]  = new_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SERVOS; i++) begin
            count_ff[i] <= '0;
         end
         flag_ff <= '0;
      end else if (en) begin
         for (int i = 0; i < SERVOS; i++) begin
            count_ff[i] <= count_in[i];
         end
         flag_ff <= flag_in;
      end
   end

   // Result fields; a failed read reports zero error and the kept flags
   always_comb begin
      err_used = read_ok ? angle_err : '0;
      prod     = {{(32-ERR_W){1'b0}}, err_used} * DIV10_MUL;

      rsp.servo_out   = servo_index;
      rsp.read_failed = ~read_ok;
      rsp.angle_err   = err_used;
      rsp.load_tenths = prod[DIV10_SHIFT+LOAD_W-1:DIV10_SHIFT];
      rsp.pressure    = flag_in[servo_index];
      rsp.changed     = flag_in[servo_index] ^ flag_ff[servo_index];
      rsp.front_any   = flag_in[0] | flag_in[1];
      rsp.back_any    = flag_in[2] | flag_in[3];
      rsp.left_any    = flag_in[1] | flag_in[3];
      rsp.right_any   = flag_in[0] | flag_in[2];
   end

`ifndef SYNTH
   // A raised flag of servo 0 always has at least one counted sample behind it
   a_flag_has_count: assert property (@(posedge clock) disable iff (reset)
      flag_ff[0] |-> (count_ff[0] != '0))
      else $error("pressure flag set with zero count");

   // A failed read leaves all tracking state untouched
   a_fail_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (en && !read_ok) |=> ($stable(flag_ff) && $stable(count_ff[0])
                            && $stable(count_ff[1]) && $stable(count_ff[2])
                            && $stable(count_ff[3])))
      else $error("state changed on a failed read");

   // Only a good read can report a flag change
   a_change_needs_ok: assert property (@(posedge clock) disable iff (reset)
      (en && rsp.changed) |-> read_ok)
      else $error("flag change reported on a failed read");
`endif

endmodule

### hw/rtl/servo_displacement_pressure_detector.sv
`timescale 1ns / 1ps

// Servo displacement pressure detector. Each sample (servo index, raw angle in
// hundredths of a degree, read-ok) yields exactly one result, in order. The
// block takes one sample per clock while rsp is not stalled: the angle error
// is worked out in front of the input register, the per-servo counter and
// flag update happens between the input register and the result register, so
// a result is valid on rsp once it has passed both registers and transfers
// when the output is not stalled. A result held in the output register does
// not stop the next sample from entering the input register; only when both
// registers are full and rsp is stalled is req_tready low. Write the
// configuration registers only while no sample is in flight.
module servo_displacement_pressure_detector import sdpd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // Sample channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // [1:0] servo_index, [17:2] servo angle, [18] read_ok, [23:19] zero
   input  logic [23:0]          req_tdata,
   // Result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [1:0] servo_out, [2] read_failed, [17:3] angle error,
   // [28:18] load_tenths, [29] pressure, [30] changed, [31] front flag OR,
   // [32] back flag OR, [33] left flag OR, [34] right flag OR, [39:35] zero
   output logic [39:0]          rsp_tdata,
   // Configuration writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ANGLE_W-1:0]   csr_wdata
);

   // Configuration registers
   logic [ERR_W-1:0]   threshold_ff;
   logic [COUNT_W-1:0] needed_ff;
   logic [ANGLE_W-1:0] target_ff [SERVOS];

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= RST_ERROR_THRESHOLD;
         needed_ff    <= RST_SAMPLES_NEEDED;
         target_ff[0] <= RST_TARGET_FRONT;
         target_ff[1] <= RST_TARGET_FRONT;
         target_ff[2] <= RST_TARGET_BACK;
         target_ff[3] <= RST_TARGET_BACK;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ERROR_THRESHOLD:    threshold_ff <= csr_wdata[ERR_W-1:0];
            REG_SAMPLES_NEEDED:     needed_ff    <= csr_wdata[COUNT_W-1:0];
            REG_TARGET_FRONT_RIGHT: target_ff[0] <= csr_wdata;
            REG_TARGET_FRONT_LEFT:  target_ff[1] <= csr_wdata;
            REG_TARGET_BACK_RIGHT:  target_ff[2] <= csr_wdata;
            REG_TARGET_BACK_LEFT:   target_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input fields and angle error
   logic [IDX_W-1:0]   in_idx;
   logic [ANGLE_W-1:0] in_raw;
   logic               in_ok;
   logic [ERR_W-1:0]   in_err;

   assign in_idx = req_tdata[1:0];
   assign in_raw = req_tdata[17:2];
   assign in_ok  = req_tdata[18];

   sdpd_err u_err (
      .servo_index (in_idx),
      .servo_angle (in_raw),
      .target      (target_ff[in_idx]),
      .angle_err   (in_err)
   );

   // Input register
   logic               s1_vld_ff;
   logic [IDX_W-1:0]   s1_idx_ff;
   logic               s1_ok_ff;
   logic [ERR_W-1:0]   s1_err_ff;
   logic               out_vld_ff;
   rsp_type            out_ff;
   rsp_type            rsp_in;
   logic               s1_go;
   logic               req_xfer;

   assign s1_go      = s1_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || s1_go;
   assign req_xfer   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_tready) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_idx_ff <= in_idx;
         s1_ok_ff  <= in_ok;
         s1_err_ff <= in_err;
      end
   end

   // State update and result fields
   sdpd_track u_track (
      .clock           (clock),
      .reset           (reset),
      .en              (s1_go),
      .servo_index     (s1_idx_ff),
      .read_ok         (s1_ok_ff),
      .angle_err       (s1_err_ff),
      .error_threshold (threshold_ff),
      .samples_needed  (needed_ff),
      .rsp             (rsp_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (s1_go) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'd0,
                        out_ff.right_any,
                        out_ff.left_any,
                        out_ff.back_any,
                        out_ff.front_any,
                        out_ff.changed,
                        out_ff.pressure,
                        out_ff.load_tenths,
                        out_ff.angle_err,
                        out_ff.read_failed,
                        out_ff.servo_out};

endmodule
